@@ design/fbnd_pkg.sv @@
// fbnd_pkg: shared types and constants of the fit-box nearest downscaler
// used by every module of the block except fbnd_div, depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package fbnd_pkg;

    localparam int CHAN_W    = 8;
    localparam int COORD_W   = 10;
    localparam int FIT_W     = 11;
    localparam int SRC_REG_W = 15;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    // register index, taken from paddr[2]
    localparam logic REG_SOURCE_WIDTH  = 1'b0;
    localparam logic REG_SOURCE_HEIGHT = 1'b1;

    typedef struct packed {
        logic              frame_start;
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
        logic [CHAN_W-1:0] alpha_in;
    } pix_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0]  red_out;
        logic [CHAN_W-1:0]  green_out;
        logic [CHAN_W-1:0]  blue_out;
        logic [CHAN_W-1:0]  alpha_out;
        logic [COORD_W-1:0] out_column;
        logic [COORD_W-1:0] out_row;
        logic [FIT_W-1:0]   scaled_width;
        logic [FIT_W-1:0]   scaled_height;
        logic               last_pixel;
        logic               size_error;
    } pix_out_t;

    typedef enum logic [1:0] {
        DIV_FIT,
        DIV_COL,
        DIV_ROW
    } div_sel_t;

    typedef struct packed {
        logic     frame_begin;
        logic     push_error;
        logic     proc_in;
        logic     proc_hold;
        logic     fit_direct;
        logic     div_start;
        div_sel_t div_sel;
        logic     fit_from_div;
        logic     col_from_div;
        logic     row_from_div;
    } ctl_cmd_t;

    typedef struct packed {
        logic size_zero;
        logic oversize;
        logic div_busy;
    } ctl_status_t;

endpackage

`default_nettype wire

@@ design/fbnd_div.sv @@
// fbnd_div: restoring divider, one quotient bit per cycle
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module fbnd_div #(
    parameter int DIVIDEND_W = 26,
    parameter int DIVISOR_W  = 15
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       busy,
    output logic [DIVIDEND_W-1:0]      quotient,
    output logic [DIVISOR_W-1:0]       remainder
);

    localparam int CntW = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg;
    logic [CntW-1:0]       cnt_reg;
    logic                  busy_reg;

    logic [DIVISOR_W:0] trial;
    logic [DIVISOR_W:0] diff;
    logic               fits;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        fits     = trial >= {1'b0, dsr_reg};
        rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CntW'(DIVIDEND_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

@@ design/fbnd_outq.sv @@
// fbnd_outq: two-entry result queue between the datapath and the result channel
// depends on fbnd_pkg
`timescale 1ns / 1ps
`default_nettype none

module fbnd_outq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire fbnd_pkg::pix_out_t push_data,
    output logic                    room,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output fbnd_pkg::pix_out_t      result
);

    fbnd_pkg::pix_out_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign pop          = (count_reg != 2'd0) && !result_stall;
    assign room         = count_reg != 2'd2;
    assign result_valid = count_reg != 2'd0;
    assign result       = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ design/fbnd_datapath.sv @@
// fbnd_datapath: frame geometry, step accumulators, raster counters and result build
// depends on fbnd_pkg and fbnd_div
`timescale 1ns / 1ps
`default_nettype none

module fbnd_datapath #(
    parameter int BOX_EDGE        = 1024,
    parameter int MAX_SOURCE_EDGE = 16384
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire fbnd_pkg::ctl_cmd_t                 cmd,
    output fbnd_pkg::ctl_status_t                   status,
    input  wire logic [fbnd_pkg::SRC_REG_W-1:0]     cfg_width,
    input  wire logic [fbnd_pkg::SRC_REG_W-1:0]     cfg_height,
    input  wire fbnd_pkg::pix_in_t                  pixel_in,
    output logic                                    push,
    output fbnd_pkg::pix_out_t                      push_data
);

    localparam int SW    = $clog2(MAX_SOURCE_EDGE + 1);
    localparam int BW    = $clog2(BOX_EDGE + 1);
    localparam int DW    = SW + BW;
    localparam int CoorW = fbnd_pkg::COORD_W;
    localparam int FitW  = fbnd_pkg::FIT_W;

    logic [SW-1:0] frame_w_reg, frame_w_next, frame_h_reg, frame_h_next;
    logic [BW-1:0] fit_w_reg, fit_w_next, fit_h_reg, fit_h_next;
    logic [SW-1:0] col_step_reg, col_step_next, row_step_reg, row_step_next;
    logic [BW-1:0] col_srem_reg, col_srem_next, row_srem_reg, row_srem_next;
    logic [SW-1:0] src_col_reg, src_col_next, src_row_reg, src_row_next;
    logic [BW-1:0] dst_col_reg, dst_col_next, dst_row_reg, dst_row_next;
    logic [SW-1:0] tgt_col_reg, tgt_col_next, tgt_row_reg, tgt_row_next;
    logic [BW-1:0] col_rem_reg, col_rem_next, row_rem_reg, row_rem_next;
    fbnd_pkg::pix_in_t hold_reg;

    logic [SW-1:0] clamp_w, clamp_h;
    logic          w_ge_h;
    logic [SW-1:0] short_edge, long_edge;

    logic [DW-1:0] div_dividend;
    logic [SW-1:0] div_divisor;
    logic          div_busy;
    logic [DW-1:0] div_q;
    logic [SW-1:0] div_r;
    logic [BW-1:0] fit_q;

    fbnd_pkg::pix_in_t pix;
    logic          proc, active, row_hit, hit, eol;
    logic [BW:0]   col_sum, row_sum;
    logic          col_wrap, row_wrap;

    // source edges saturate at the largest supported size
    always_comb
    begin
        clamp_w = (32'(cfg_width) > MAX_SOURCE_EDGE) ? SW'(MAX_SOURCE_EDGE) : SW'(cfg_width);
        clamp_h = (32'(cfg_height) > MAX_SOURCE_EDGE) ? SW'(MAX_SOURCE_EDGE) : SW'(cfg_height);
    end

    assign w_ge_h     = frame_w_reg >= frame_h_reg;
    assign short_edge = w_ge_h ? frame_h_reg : frame_w_reg;
    assign long_edge  = w_ge_h ? frame_w_reg : frame_h_reg;

    assign status.size_zero = (cfg_width == '0) || (cfg_height == '0);
    assign status.oversize  = (32'(frame_w_reg) > BOX_EDGE) || (32'(frame_h_reg) > BOX_EDGE);
    assign status.div_busy  = div_busy;

    always_comb
    begin
        case (cmd.div_sel)
            fbnd_pkg::DIV_FIT:
            begin
                div_dividend = DW'(short_edge) * DW'(BOX_EDGE);
                div_divisor  = long_edge;
            end
            fbnd_pkg::DIV_COL:
            begin
                div_dividend = DW'(frame_w_reg);
                div_divisor  = SW'(fit_w_reg);
            end
            fbnd_pkg::DIV_ROW:
            begin
                div_dividend = DW'(frame_h_reg);
                div_divisor  = SW'(fit_h_reg);
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    fbnd_div #(
        .DIVIDEND_W (DW),
        .DIVISOR_W  (SW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // fitted short edge never drops below one pixel
    assign fit_q = (div_q == '0) ? BW'(1) : BW'(div_q);

    assign pix  = cmd.proc_hold ? hold_reg : pixel_in;
    assign proc = cmd.proc_in || cmd.proc_hold;

    always_comb
    begin
        active   = (fit_w_reg != '0) && (fit_h_reg != '0) && (src_row_reg < frame_h_reg);
        row_hit  = (src_row_reg == tgt_row_reg) && (dst_row_reg < fit_h_reg);
        hit      = row_hit && (src_col_reg == tgt_col_reg) && (dst_col_reg < fit_w_reg);
        eol      = ({1'b0, src_col_reg} + 1'b1) >= {1'b0, frame_w_reg};
        col_sum  = {1'b0, col_rem_reg} + {1'b0, col_srem_reg};
        row_sum  = {1'b0, row_rem_reg} + {1'b0, row_srem_reg};
        col_wrap = col_sum >= {1'b0, fit_w_reg};
        row_wrap = row_sum >= {1'b0, fit_h_reg};
    end

    always_comb
    begin
        frame_w_next  = frame_w_reg;
        frame_h_next  = frame_h_reg;
        fit_w_next    = fit_w_reg;
        fit_h_next    = fit_h_reg;
        col_step_next = col_step_reg;
        row_step_next = row_step_reg;
        col_srem_next = col_srem_reg;
        row_srem_next = row_srem_reg;
        src_col_next  = src_col_reg;
        src_row_next  = src_row_reg;
        dst_col_next  = dst_col_reg;
        dst_row_next  = dst_row_reg;
        tgt_col_next  = tgt_col_reg;
        tgt_row_next  = tgt_row_reg;
        col_rem_next  = col_rem_reg;
        row_rem_next  = row_rem_reg;

        if (cmd.frame_begin)
        begin
            frame_w_next  = clamp_w;
            frame_h_next  = clamp_h;
            fit_w_next    = '0;
            fit_h_next    = '0;
            col_step_next = '0;
            row_step_next = '0;
            col_srem_next = '0;
            row_srem_next = '0;
            src_col_next  = '0;
            src_row_next  = '0;
            dst_col_next  = '0;
            dst_row_next  = '0;
            tgt_col_next  = '0;
            tgt_row_next  = '0;
            col_rem_next  = '0;
            row_rem_next  = '0;
        end
        else if (cmd.fit_direct)
        begin
            fit_w_next = BW'(frame_w_reg);
            fit_h_next = BW'(frame_h_reg);
        end
        else if (cmd.fit_from_div)
        begin
            if (w_ge_h)
            begin
                fit_w_next = BW'(BOX_EDGE);
                fit_h_next = fit_q;
            end
            else
            begin
                fit_w_next = fit_q;
                fit_h_next = BW'(BOX_EDGE);
            end
        end
        else if (cmd.col_from_div)
        begin
            col_step_next = SW'(div_q);
            col_srem_next = BW'(div_r);
        end
        else if (cmd.row_from_div)
        begin
            row_step_next = SW'(div_q);
            row_srem_next = BW'(div_r);
        end
        else if (proc && active)
        begin
            if (hit)
            begin
                dst_col_next = dst_col_reg + 1'b1;
                col_rem_next = col_wrap ? BW'(col_sum - {1'b0, fit_w_reg}) : BW'(col_sum);
                tgt_col_next = tgt_col_reg + col_step_reg + SW'(col_wrap);
            end
            if (eol)
            begin
                if (row_hit)
                begin
                    dst_row_next = dst_row_reg + 1'b1;
                    row_rem_next = row_wrap ? BW'(row_sum - {1'b0, fit_h_reg}) : BW'(row_sum);
                    tgt_row_next = tgt_row_reg + row_step_reg + SW'(row_wrap);
                end
                src_col_next = '0;
                src_row_next = src_row_reg + 1'b1;
                dst_col_next = '0;
                tgt_col_next = '0;
                col_rem_next = '0;
            end
            else
            begin
                src_col_next = src_col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_w_reg  <= '0;
            frame_h_reg  <= '0;
            fit_w_reg    <= '0;
            fit_h_reg    <= '0;
            col_step_reg <= '0;
            row_step_reg <= '0;
            col_srem_reg <= '0;
            row_srem_reg <= '0;
            src_col_reg  <= '0;
            src_row_reg  <= '0;
            dst_col_reg  <= '0;
            dst_row_reg  <= '0;
            tgt_col_reg  <= '0;
            tgt_row_reg  <= '0;
            col_rem_reg  <= '0;
            row_rem_reg  <= '0;
        end
        else
        begin
            frame_w_reg  <= frame_w_next;
            frame_h_reg  <= frame_h_next;
            fit_w_reg    <= fit_w_next;
            fit_h_reg    <= fit_h_next;
            col_step_reg <= col_step_next;
            row_step_reg <= row_step_next;
            col_srem_reg <= col_srem_next;
            row_srem_reg <= row_srem_next;
            src_col_reg  <= src_col_next;
            src_row_reg  <= src_row_next;
            dst_col_reg  <= dst_col_next;
            dst_row_reg  <= dst_row_next;
            tgt_col_reg  <= tgt_col_next;
            tgt_row_reg  <= tgt_row_next;
            col_rem_reg  <= col_rem_next;
            row_rem_reg  <= row_rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.frame_begin)
        begin
            hold_reg <= pixel_in;
        end
    end

    assign push = cmd.push_error || (proc && active && hit);

    always_comb
    begin
        if (cmd.push_error)
        begin
            push_data            = '0;
            push_data.size_error = 1'b1;
        end
        else
        begin
            push_data.red_out       = pix.red_in;
            push_data.green_out     = pix.green_in;
            push_data.blue_out      = pix.blue_in;
            push_data.alpha_out     = pix.alpha_in;
            push_data.out_column    = CoorW'(dst_col_reg);
            push_data.out_row       = CoorW'(dst_row_reg);
            push_data.scaled_width  = FitW'(fit_w_reg);
            push_data.scaled_height = FitW'(fit_h_reg);
            push_data.last_pixel    = (({1'b0, dst_col_reg} + 1'b1) == {1'b0, fit_w_reg})
                                   && (({1'b0, dst_row_reg} + 1'b1) == {1'b0, fit_h_reg});
            push_data.size_error    = 1'b0;
        end
    end

endmodule

`default_nettype wire

@@ design/fbnd_ctrl.sv @@
// fbnd_ctrl: sequencer for pixel requests and the per-frame divisions
// depends on fbnd_pkg
`timescale 1ns / 1ps
`default_nettype none

module fbnd_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  pixel_valid,
    input  wire logic                  frame_start,
    input  wire logic                  room,
    input  wire fbnd_pkg::ctl_status_t status,
    output fbnd_pkg::ctl_cmd_t         cmd,
    output logic                       pixel_stall
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIT,
        S_FIT_WAIT,
        S_COL,
        S_COL_WAIT,
        S_ROW,
        S_ROW_WAIT,
        S_PIXEL
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign pixel_stall = !((state_reg == S_IDLE) && room);
    assign accept      = pixel_valid && !pixel_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = fbnd_pkg::DIV_FIT;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (frame_start)
                    begin
                        cmd.frame_begin = 1'b1;
                        if (status.size_zero)
                        begin
                            cmd.push_error = 1'b1;
                        end
                        else
                        begin
                            state_next = S_FIT;
                        end
                    end
                    else
                    begin
                        cmd.proc_in = 1'b1;
                    end
                end
            end
            S_FIT:
            begin
                if (status.oversize)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_FIT_WAIT;
                end
                else
                begin
                    cmd.fit_direct = 1'b1;
                    state_next     = S_COL;
                end
            end
            S_FIT_WAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.fit_from_div = 1'b1;
                    state_next       = S_COL;
                end
            end
            S_COL:
            begin
                cmd.div_sel   = fbnd_pkg::DIV_COL;
                cmd.div_start = 1'b1;
                state_next    = S_COL_WAIT;
            end
            S_COL_WAIT:
            begin
                cmd.div_sel = fbnd_pkg::DIV_COL;
                if (!status.div_busy)
                begin
                    cmd.col_from_div = 1'b1;
                    state_next       = S_ROW;
                end
            end
            S_ROW:
            begin
                cmd.div_sel   = fbnd_pkg::DIV_ROW;
                cmd.div_start = 1'b1;
                state_next    = S_ROW_WAIT;
            end
            S_ROW_WAIT:
            begin
                cmd.div_sel = fbnd_pkg::DIV_ROW;
                if (!status.div_busy)
                begin
                    cmd.row_from_div = 1'b1;
                    state_next       = S_PIXEL;
                end
            end
            S_PIXEL:
            begin
                if (room)
                begin
                    cmd.proc_hold = 1'b1;
                    state_next    = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ design/fit_box_nearest_downscaler.sv @@
// fit_box_nearest_downscaler: nearest-neighbour rgba downscaler into a square box
// an ordinary pixel request is decided at its accept edge, a kept result is queued there
// throughput: one pixel request per cycle while idle and the two-entry result queue has room
// frame start: the fit division (only if an edge exceeds the box) and the step divisions
//   run on the one-bit-per-cycle divider, dividend width clog2(MAX+1)+clog2(BOX+1)
// reset: asynchronous, clears sizes, counters and queue; no frame is active after reset
`timescale 1ns / 1ps
`default_nettype none

module fit_box_nearest_downscaler #(
    parameter int BOX_EDGE        = 1024,
    parameter int MAX_SOURCE_EDGE = 16384
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // pixel request channel
    input  wire logic                          pixel_valid,
    output logic                               pixel_stall,
    input  wire fbnd_pkg::pix_in_t             pixel,
    // kept pixel channel
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output fbnd_pkg::pix_out_t                 result,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fbnd_pkg::APB_AW-1:0]   paddr,
    input  wire logic [fbnd_pkg::APB_DW-1:0]   pwdata,
    output logic [fbnd_pkg::APB_DW-1:0]        prdata,
    output logic                               pready
);

    localparam int RegW = fbnd_pkg::SRC_REG_W;
    localparam int DatW = fbnd_pkg::APB_DW;

    logic [RegW-1:0] src_width_reg;
    logic [RegW-1:0] src_height_reg;
    logic            cfg_write;

    fbnd_pkg::ctl_cmd_t    cmd;
    fbnd_pkg::ctl_status_t status;
    logic                  push;
    fbnd_pkg::pix_out_t    push_data;
    logic                  room;

    // register file, index taken from paddr[2], writes land on the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= '0;
            src_height_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                fbnd_pkg::REG_SOURCE_WIDTH:  src_width_reg  <= pwdata[RegW-1:0];
                fbnd_pkg::REG_SOURCE_HEIGHT: src_height_reg <= pwdata[RegW-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            fbnd_pkg::REG_SOURCE_WIDTH:  prdata = DatW'(src_width_reg);
            fbnd_pkg::REG_SOURCE_HEIGHT: prdata = DatW'(src_height_reg);
        endcase
    end

    // sequencer: takes requests when idle, walks through the frame set-up divisions
    fbnd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .frame_start (pixel.frame_start),
        .room        (room),
        .status      (status),
        .cmd         (cmd),
        .pixel_stall (pixel_stall)
    );

    // geometry, accumulators and raster counters
    fbnd_datapath #(
        .BOX_EDGE        (BOX_EDGE),
        .MAX_SOURCE_EDGE (MAX_SOURCE_EDGE)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_width  (src_width_reg),
        .cfg_height (src_height_reg),
        .pixel_in   (pixel),
        .push       (push),
        .push_data  (push_data)
    );

    // result queue parts the request side from the result side
    fbnd_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_data    (push_data),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire
